// File: src/bir_pkg.sv
// ---------------------------------------------------------------------------
// bir_pkg - shared types and constants of the bilinear image rotator
// Item formats, register indexes, job format between front and back.
// ---------------------------------------------------------------------------
package bir_pkg;

    localparam int MAX_DIM  = 64;
    localparam int IDX_W    = 6;
    localparam int DIM_W    = 7;
    localparam int PIX_W    = 8;
    localparam int ROT_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int W_W      = 10;

    // commands
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_COLS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_ROWS  = 3'd5;

    // reset values
    localparam logic [ROT_W-1:0] ROT_X_RST = 16'd16384;
    localparam logic [ROT_W-1:0] ROT_Y_RST = 16'd0;
    localparam logic [DIM_W-1:0] DIM_RST   = 7'd64;

    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] column_index;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_row;
        logic [IDX_W-1:0] out_column;
        logic [PIX_W-1:0] pixel_out;
        logic             inside_res;
    } out_item_t;

    // classified job handed from front to back
    typedef struct packed {
        logic                  is_write;
        logic                  in_src;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic [PIX_W-1:0]      pixel;
        logic [IDX_W-1:0]      top;
        logic [IDX_W-1:0]      bottom;
        logic [IDX_W-1:0]      left;
        logic [IDX_W-1:0]      right;
        logic signed [W_W-1:0] wx;
        logic signed [W_W-1:0] wy;
    } job_t;

    localparam int JOB_W = $bits(job_t);
    localparam int OUT_W = $bits(out_item_t);

    // dimension register as used: zero acts as one, above MAX_DIM as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

// File: src/bilinear_image_rotator.sv
// ---------------------------------------------------------------------------
// bilinear_image_rotator - rotated resampling of a stored source image
// Top level: front calculation, job queue and store/interpolation back end.
// ---------------------------------------------------------------------------
// Input channel: push/full. A write item (command 0) stores pixel_in at
// row_index/column_index; a request item (command 1) asks for one
// destination pixel and later yields one result item.
// Result channel: empty/pop. The oldest result is on result while empty is
// low and leaves at a clock edge with pop high.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index selects the
// register, cfg_data carries the value. Write only while the block is idle.
// A request passes front stages 1 and 2, the job queue, the store reads
// and back-end stages A, B and C before the result queue; a request
// outside the source skips the store reads. A write makes one store
// access, a request four neighbour reads through the single store port,
// a request outside the source none. The front takes a new item every
// cycle until the job queue fills.
// Reset: registers return to their defaults and queues empty; the image
// store keeps no defined contents until written.
// A stalled receiver fills the result queue, then the back end stops taking
// request jobs, then the job queue fills and full rises.
// ---------------------------------------------------------------------------
module bilinear_image_rotator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  bir_pkg::in_item_t                 in_item,
    output logic                              empty,
    input  logic                              pop,
    output bir_pkg::out_item_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bir_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import bir_pkg::*;

    localparam int JDEPTH = 4;

    logic       job_valid, job_full, job_empty, job_pop;
    job_t       job_new, job_head;
    logic [$clog2(JDEPTH+1)-1:0] job_count;
    logic       unused_ok;

    assign cfg_ready = 1'b1;
    assign unused_ok = ^job_count;

    bir_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (job_valid),
        .job       (job_new),
        .job_full  (job_full)
    );

    // job queue between front and back
    bir_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JDEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (job_new),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .full    (job_full),
        .empty   (job_empty),
        .count   (job_count)
    );

    bir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// File: src/bir_fifo.sv
// ---------------------------------------------------------------------------
// bir_fifo - small synchronous queue
// Register-based first-in first-out queue with fill count.
// ---------------------------------------------------------------------------
module bir_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = store_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: src/bir_front.sv
// ---------------------------------------------------------------------------
// bir_front - item intake and position calculation
// Holds the registers, rotates the destination position and classifies.
// ---------------------------------------------------------------------------
module bir_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  bir_pkg::in_item_t                 in_item,
    input  logic                              cfg_valid,
    input  logic [bir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bir_pkg::CFG_DAT_W-1:0]     cfg_data,
    output logic                              job_valid,
    output bir_pkg::job_t                     job,
    input  logic                              job_full
);
    import bir_pkg::*;

    logic [ROT_W-1:0] rot_x_reg, rot_y_reg;
    logic [DIM_W-1:0] src_cols_reg, src_rows_reg, dst_cols_reg, dst_rows_reg;
    logic [DIM_W-1:0] sc, sr, dc, dr;
    logic             en;

    // stage 1
    logic             s1_valid_reg;
    in_item_t         s1_item_reg;
    logic             s1_out_reg;
    logic signed [7:0] s1_ax_reg, s1_ay_reg;

    // stage 2
    logic             s2_valid_reg;
    in_item_t         s2_item_reg;
    logic             s2_out_reg;
    logic signed [23:0] p_xx_reg, p_yy_reg, p_yx_reg, p_xy_reg;

    // stage 3 combinational
    logic signed [24:0] sx, sy;
    logic signed [18:0] px, py;
    logic [18:0]        pxr, pyr, xlim, ylim;
    logic [DIM_W-1:0]   right_raw, bottom_raw, left7, top7, right7, bottom7;
    logic [18:0]        wx19, wy19;
    logic               in_x, in_y;

    assign sc = eff_dim(src_cols_reg);
    assign sr = eff_dim(src_rows_reg);
    assign dc = eff_dim(dst_cols_reg);
    assign dr = eff_dim(dst_rows_reg);

    assign en   = !(s2_valid_reg && job_full);
    assign full = !en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg    <= ROT_X_RST;
            rot_y_reg    <= ROT_Y_RST;
            src_cols_reg <= DIM_RST;
            src_rows_reg <= DIM_RST;
            dst_cols_reg <= DIM_RST;
            dst_rows_reg <= DIM_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROT_X:    rot_x_reg    <= cfg_data;
                REG_ROT_Y:    rot_y_reg    <= cfg_data;
                REG_SRC_COLS: src_cols_reg <= cfg_data[DIM_W-1:0];
                REG_SRC_ROWS: src_rows_reg <= cfg_data[DIM_W-1:0];
                REG_DST_COLS: dst_cols_reg <= cfg_data[DIM_W-1:0];
                REG_DST_ROWS: dst_rows_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= push;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage 1: offset from destination centre in half pixels
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= in_item;
            s1_out_reg  <= ({1'b0, in_item.row_index} >= dr) ||
                           ({1'b0, in_item.column_index} >= dc);
            s1_ax_reg   <= $signed({1'b0, in_item.column_index, 1'b1}) - $signed({1'b0, dc});
            s1_ay_reg   <= $signed({1'b0, in_item.row_index, 1'b1}) - $signed({1'b0, dr});
        end
    end

    // stage 2: rotation products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_item_reg <= s1_item_reg;
            s2_out_reg  <= s1_out_reg;
            p_xx_reg    <= s1_ax_reg * $signed(rot_x_reg);
            p_yy_reg    <= s1_ay_reg * $signed(rot_y_reg);
            p_yx_reg    <= s1_ay_reg * $signed(rot_x_reg);
            p_xy_reg    <= s1_ax_reg * $signed(rot_y_reg);
        end
    end

    // stage 3: source position, bounds, neighbours and weights
    always_comb
    begin
        sx   = {p_xx_reg[23], p_xx_reg} + {p_yy_reg[23], p_yy_reg};
        sy   = {p_yx_reg[23], p_yx_reg} - {p_xy_reg[23], p_xy_reg};
        px   = $signed({5'b0, sc, 7'b0}) + $signed({sx[24], sx[24:7]});
        py   = $signed({5'b0, sr, 7'b0}) + $signed({sy[24], sy[24:7]});
        xlim = {4'b0, sc, 8'b0};
        ylim = {4'b0, sr, 8'b0};
        in_x = !px[18] && ($unsigned(px) < xlim);
        in_y = !py[18] && ($unsigned(py) < ylim);
        pxr  = $unsigned(px) + 19'd128;
        pyr  = $unsigned(py) + 19'd128;
        right_raw  = pxr[14:8];
        bottom_raw = pyr[14:8];
        left7   = (right_raw == '0) ? '0 : right_raw - 1'b1;
        top7    = (bottom_raw == '0) ? '0 : bottom_raw - 1'b1;
        right7  = (right_raw > sc - 1'b1) ? sc - 1'b1 : right_raw;
        bottom7 = (bottom_raw > sr - 1'b1) ? sr - 1'b1 : bottom_raw;
        wx19 = $unsigned(px) - 19'd128 - {4'b0, left7, 8'b0};
        wy19 = $unsigned(py) - 19'd128 - {4'b0, top7, 8'b0};

        job.is_write = (s2_item_reg.command == CMD_WRITE);
        job.in_src   = !s2_out_reg && in_x && in_y;
        job.row      = s2_item_reg.row_index;
        job.col      = s2_item_reg.column_index;
        job.pixel    = s2_item_reg.pixel_in;
        job.top      = top7[IDX_W-1:0];
        job.bottom   = bottom7[IDX_W-1:0];
        job.left     = left7[IDX_W-1:0];
        job.right    = right7[IDX_W-1:0];
        job.wx       = $signed(wx19[W_W-1:0]);
        job.wy       = $signed(wy19[W_W-1:0]);
    end

    assign job_valid = s2_valid_reg && !job_full;

endmodule

// File: src/bir_back.sv
// ---------------------------------------------------------------------------
// bir_back - image store, neighbour fetch and interpolation
// Runs one job at a time over the single store port, then interpolates.
// ---------------------------------------------------------------------------
module bir_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_empty,
    input  bir_pkg::job_t          job_head,
    output logic                   job_pop,
    output logic                   empty,
    input  logic                   pop,
    output bir_pkg::out_item_t     result
);
    import bir_pkg::*;

    localparam int ODEPTH = 4;
    localparam int OCW    = $clog2(ODEPTH + 1);

    logic [PIX_W-1:0] mem [MAX_DIM * MAX_DIM];

    logic             busy_reg;
    logic [1:0]       phase_reg;
    job_t             cur_reg;
    logic             last_cycle, take, credit_ok, is_req_in, is_outside;
    logic [OCW-1:0]   inflight_reg, ocount;
    logic [OCW:0]     used;

    logic             rd_valid_reg;
    logic [1:0]       rd_phase_reg;
    logic [PIX_W-1:0] rd_data_reg;
    logic [PIX_W-1:0] p0_reg, p1_reg, p2_reg;
    logic [ADDR_W-1:0] addr;

    // stage A
    logic             a_valid_reg, a_inside_reg;
    logic [IDX_W-1:0] a_row_reg, a_col_reg;
    logic signed [W_W-1:0] a_wx_reg, a_wy_reg;
    // stage B
    logic             b_valid_reg, b_inside_reg;
    logic [IDX_W-1:0] b_row_reg, b_col_reg;
    logic signed [W_W-1:0] b_wy_reg;
    logic signed [19:0] b_t_reg, b_b_reg;
    // stage C
    logic             c_valid_reg, c_inside_reg;
    logic [IDX_W-1:0] c_row_reg, c_col_reg;
    logic signed [31:0] c_v_reg;

    logic signed [8:0]  d_top, d_bot;
    logic signed [18:0] m_top, m_bot;
    logic signed [19:0] t_val, b_val;
    logic signed [20:0] d_bt;
    logic signed [30:0] m_v;
    logic signed [31:0] v_val;
    logic [PIX_W-1:0]   pix_fin;
    out_item_t          res_in;
    logic               ofull;

    // job sequencing over the store port
    assign is_req_in  = !cur_reg.is_write && cur_reg.in_src;
    assign is_outside = !cur_reg.is_write && !cur_reg.in_src;
    assign last_cycle = busy_reg && (!is_req_in || phase_reg == 2'd3);
    assign used       = {1'b0, inflight_reg} + {1'b0, ocount};
    assign credit_ok  = (used < (OCW + 1)'(ODEPTH));
    assign take       = !job_empty && (!busy_reg || last_cycle) &&
                        (job_head.is_write || credit_ok);
    assign job_pop    = take;

    always_comb
    begin
        unique case (phase_reg)
            2'd0:    addr = {cur_reg.top, cur_reg.left};
            2'd1:    addr = {cur_reg.top, cur_reg.right};
            2'd2:    addr = {cur_reg.bottom, cur_reg.left};
            default: addr = {cur_reg.bottom, cur_reg.right};
        endcase
        if (cur_reg.is_write)
            addr = {cur_reg.row, cur_reg.col};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            phase_reg    <= '0;
            inflight_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_phase_reg <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= '0;
            end
            else if (last_cycle)
                busy_reg <= 1'b0;
            else if (busy_reg)
                phase_reg <= phase_reg + 1'b1;

            if ((take && !job_head.is_write) && !c_valid_reg)
                inflight_reg <= inflight_reg + 1'b1;
            else if (!(take && !job_head.is_write) && c_valid_reg)
                inflight_reg <= inflight_reg - 1'b1;

            rd_valid_reg <= busy_reg && is_req_in;
            rd_phase_reg <= phase_reg;
            a_valid_reg  <= busy_reg && (is_outside || (is_req_in && phase_reg == 2'd3));
            b_valid_reg  <= a_valid_reg;
            c_valid_reg  <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= job_head;
    end

    // image store: one access per cycle
    always_ff @(posedge clk)
    begin
        if (busy_reg && cur_reg.is_write)
            mem[addr] <= cur_reg.pixel;
        else if (busy_reg && is_req_in)
            rd_data_reg <= mem[addr];
    end

    // neighbour capture
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg && rd_phase_reg == 2'd0)
            p0_reg <= rd_data_reg;
        if (rd_valid_reg && rd_phase_reg == 2'd1)
            p1_reg <= rd_data_reg;
        if (rd_valid_reg && rd_phase_reg == 2'd2)
            p2_reg <= rd_data_reg;
    end

    // stage A payload
    always_ff @(posedge clk)
    begin
        a_inside_reg <= cur_reg.in_src;
        a_row_reg    <= cur_reg.row;
        a_col_reg    <= cur_reg.col;
        a_wx_reg     <= cur_reg.wx;
        a_wy_reg     <= cur_reg.wy;
    end

    // horizontal interpolation
    always_comb
    begin
        d_top = $signed({1'b0, p1_reg}) - $signed({1'b0, p0_reg});
        d_bot = $signed({1'b0, rd_data_reg}) - $signed({1'b0, p2_reg});
        m_top = a_wx_reg * d_top;
        m_bot = a_wx_reg * d_bot;
        t_val = $signed({4'b0, p0_reg, 8'b0}) + $signed({m_top[18], m_top});
        b_val = $signed({4'b0, p2_reg, 8'b0}) + $signed({m_bot[18], m_bot});
    end

    always_ff @(posedge clk)
    begin
        b_inside_reg <= a_inside_reg;
        b_row_reg    <= a_row_reg;
        b_col_reg    <= a_col_reg;
        b_wy_reg     <= a_wy_reg;
        b_t_reg      <= t_val;
        b_b_reg      <= b_val;
    end

    // vertical interpolation
    always_comb
    begin
        d_bt  = $signed({b_b_reg[19], b_b_reg}) - $signed({b_t_reg[19], b_t_reg});
        m_v   = b_wy_reg * d_bt;
        v_val = $signed({{4{b_t_reg[19]}}, b_t_reg, 8'b0}) + $signed({m_v[30], m_v});
    end

    always_ff @(posedge clk)
    begin
        c_inside_reg <= b_inside_reg;
        c_row_reg    <= b_row_reg;
        c_col_reg    <= b_col_reg;
        c_v_reg      <= v_val;
    end

    // clamp and truncate to a pixel
    always_comb
    begin
        if (!c_inside_reg || c_v_reg[31])
            pix_fin = '0;
        else if (|c_v_reg[30:24])
            pix_fin = '1;
        else
            pix_fin = c_v_reg[23:16];
        res_in.out_row    = c_row_reg;
        res_in.out_column = c_col_reg;
        res_in.pixel_out  = pix_fin;
        res_in.inside_res = c_inside_reg;
    end

    // result queue, space reserved when a request job is taken
    bir_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (ODEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (c_valid_reg),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (result),
        .full    (ofull),
        .empty   (empty),
        .count   (ocount)
    );

    logic unused_ok;
    assign unused_ok = ofull;

endmodule
